[sv/nvcd_pkg.sv]
// ----------------------------------------------------------------------------
// nvcd_pkg
// Shared types, codes and helper functions of the nested vector column decoder.
// ----------------------------------------------------------------------------
package nvcd_pkg;

  // status codes of the column done transaction
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_HEADER_SHORT  = 4'd1;
  localparam logic [3:0] ST_OUTER_LIMIT   = 4'd2;
  localparam logic [3:0] ST_NO_MARKER     = 4'd3;
  localparam logic [3:0] ST_COUNT_SHORT   = 4'd4;
  localparam logic [3:0] ST_COUNT_EXCEEDS = 4'd5;
  localparam logic [3:0] ST_CSUM_TRUNC    = 4'd6;
  localparam logic [3:0] ST_LEN_TRUNC     = 4'd7;
  localparam logic [3:0] ST_NEG_COUNT     = 4'd8;
  localparam logic [3:0] ST_VALUE_LIMIT   = 4'd9;
  localparam logic [3:0] ST_PAYLOAD_TRUNC = 4'd10;
  localparam logic [3:0] ST_BAD_KIND      = 4'd11;
  localparam logic [3:0] ST_SIZE_MISMATCH = 4'd12;

  // primitive kinds
  localparam logic [3:0] KIND_BOOL    = 4'd0;
  localparam logic [3:0] KIND_INT8    = 4'd1;
  localparam logic [3:0] KIND_UINT8   = 4'd2;
  localparam logic [3:0] KIND_INT16   = 4'd3;
  localparam logic [3:0] KIND_UINT16  = 4'd4;
  localparam logic [3:0] KIND_INT32   = 4'd5;
  localparam logic [3:0] KIND_UINT32  = 4'd6;
  localparam logic [3:0] KIND_FLOAT32 = 4'd7;
  localparam logic [3:0] KIND_INT64   = 4'd8;
  localparam logic [3:0] KIND_UINT64  = 4'd9;
  localparam logic [3:0] KIND_FLOAT64 = 4'd10;

  // configuration register indexes
  localparam logic CFG_VALUE_KIND = 1'b0;
  localparam logic CFG_MAX_TOTAL  = 1'b1;

  // header framing
  localparam logic [31:0] MARK_BIT         = 32'h4000_0000;
  localparam logic [31:0] COUNT_MASK       = 32'h3fff_ffff;
  localparam logic [32:0] COUNT_WORD_BYTES = 33'd4;
  localparam logic [32:0] HEADER_BYTES     = 33'd6;

  // one result before conversion to binary64
  typedef struct packed {
    logic [63:0] raw;
    logic [3:0]  kind;
    logic        has_value;
    logic [30:0] outer_index;
    logic [30:0] inner_index;
    logic        column_done;
    logic [3:0]  status;
  } nvcd_entry_t;

  // bytes per primitive, zero for an unknown kind
  function automatic logic [3:0] kind_width(logic [3:0] k);
    logic [3:0] w;
    if (k <= KIND_UINT8) w = 4'd1;
    else if (k <= KIND_UINT16) w = 4'd2;
    else if (k <= KIND_FLOAT32) w = 4'd4;
    else if (k <= KIND_FLOAT64) w = 4'd8;
    else w = 4'd0;
    return w;
  endfunction

  // log2 of the primitive width
  function automatic logic [1:0] kind_shift(logic [3:0] k);
    logic [1:0] s;
    if (k <= KIND_UINT8) s = 2'd0;
    else if (k <= KIND_UINT16) s = 2'd1;
    else if (k <= KIND_FLOAT32) s = 2'd2;
    else s = 2'd3;
    return s;
  endfunction

endpackage

[sv/nvcd_parser.sv]
// ----------------------------------------------------------------------------
// nvcd_parser
// Byte-wise column parser: header checks, counts and value assembly.
// ----------------------------------------------------------------------------
module nvcd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 first_byte_i,
  input  logic [31:0]          column_available_i,
  input  logic [31:0]          outer_vectors_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output nvcd_pkg::nvcd_entry_t ent_a_o,
  output nvcd_pkg::nvcd_entry_t ent_b_o,
  output logic [1:0]           n_push_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_VERSION, PH_CHECKSUM, PH_LEN, PH_VALUE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [31:0] header_q, header_d;
  logic [31:0] outer_cnt_q, outer_cnt_d;
  logic [31:0] outer_tgt_q, outer_tgt_d;
  logic [31:0] inner_cnt_q, inner_cnt_d;
  logic [31:0] inner_tgt_q, inner_tgt_d;
  logic [63:0] shift_q, shift_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] total_q, total_d;
  logic [3:0]  col_kind_q, col_kind_d;
  logic [31:0] col_avail_q, col_avail_d;
  logic [3:0]  cfg_kind_q;
  logic [31:0] cfg_max_q;

  logic        val_emit, fin_emit;
  logic [3:0]  fin_status;
  logic [63:0] val_raw;
  logic [30:0] val_oi, val_ii;

  // parse one byte
  always_comb begin
    logic [32:0] decl;
    logic [31:0] cnt;
    logic [31:0] room;
    logic [34:0] need;
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    header_d     = header_q;
    outer_cnt_d  = outer_cnt_q;
    outer_tgt_d  = outer_tgt_q;
    inner_cnt_d  = inner_cnt_q;
    inner_tgt_d  = inner_tgt_q;
    shift_d      = shift_q;
    pos_d        = pos_q;
    total_d      = total_q;
    col_kind_d   = col_kind_q;
    col_avail_d  = col_avail_q;
    val_emit     = 1'b0;
    fin_emit     = 1'b0;
    fin_status   = nvcd_pkg::ST_OK;
    val_raw      = '0;
    val_oi       = '0;
    val_ii       = '0;
    decl         = '0;
    cnt          = '0;
    room         = '0;
    need         = '0;

    if (accept_i) begin
      // column start: latch and check
      if (first_byte_i) begin
        col_avail_d  = column_available_i;
        col_kind_d   = cfg_kind_q;
        outer_cnt_d  = '0;
        outer_tgt_d  = outer_vectors_i;
        inner_cnt_d  = '0;
        inner_tgt_d  = '0;
        total_d      = '0;
        header_d     = '0;
        shift_d      = '0;
        pos_d        = '0;
        bytes_left_d = '0;
        phase_d      = PH_IDLE;
        if (nvcd_pkg::kind_width(cfg_kind_q) == 4'd0) begin
          fin_emit = 1'b1; fin_status = nvcd_pkg::ST_BAD_KIND;
        end else if ({1'b0, column_available_i} < nvcd_pkg::HEADER_BYTES) begin
          fin_emit = 1'b1; fin_status = nvcd_pkg::ST_HEADER_SHORT;
        end else if (outer_vectors_i[31] || (outer_vectors_i > cfg_max_q)) begin
          fin_emit = 1'b1; fin_status = nvcd_pkg::ST_OUTER_LIMIT;
        end else begin
          phase_d = PH_COUNT;
        end
      end

      // the open-ended tail of each phase is handled below via next-outer
      unique case (phase_d)
        PH_COUNT: begin
          header_d = {header_d[23:0], data_byte_i};
          pos_d    = pos_d + 4'd1;
          if (pos_d == 4'd4) begin
            decl = {1'b0, header_d & nvcd_pkg::COUNT_MASK} + nvcd_pkg::COUNT_WORD_BYTES;
            if ((header_d & nvcd_pkg::MARK_BIT) == '0) begin
              fin_emit = 1'b1; fin_status = nvcd_pkg::ST_NO_MARKER;
            end else if (decl < nvcd_pkg::HEADER_BYTES) begin
              fin_emit = 1'b1; fin_status = nvcd_pkg::ST_COUNT_SHORT;
            end else if (decl > {1'b0, col_avail_d}) begin
              fin_emit = 1'b1; fin_status = nvcd_pkg::ST_COUNT_EXCEEDS;
            end else begin
              bytes_left_d = header_d & nvcd_pkg::COUNT_MASK;
              phase_d      = PH_VERSION;
              pos_d        = '0;
              shift_d      = '0;
            end
          end
        end
        PH_VERSION: begin
          bytes_left_d = bytes_left_d - 32'd1;
          shift_d      = {48'd0, shift_d[7:0], data_byte_i};
          pos_d        = pos_d + 4'd1;
          if (pos_d == 4'd2) begin
            pos_d = '0;
            if (shift_d == '0) begin
              if (bytes_left_d < 32'd4) begin
                fin_emit = 1'b1; fin_status = nvcd_pkg::ST_CSUM_TRUNC;
              end else begin
                phase_d = PH_CHECKSUM;
              end
            end else begin
              phase_d = PH_LEN; // resolved by next-outer below
            end
          end
        end
        PH_CHECKSUM: begin
          bytes_left_d = bytes_left_d - 32'd1;
          pos_d        = pos_d + 4'd1;
          if (pos_d == 4'd4) phase_d = PH_LEN;
        end
        PH_LEN: begin
          bytes_left_d = bytes_left_d - 32'd1;
          shift_d      = {32'd0, shift_d[23:0], data_byte_i};
          pos_d        = pos_d + 4'd1;
          if (pos_d == 4'd4) begin
            cnt  = shift_d[31:0];
            room = ({32'd0, total_d} <= {32'd0, cfg_max_q}) ? (cfg_max_q - total_d) : '0;
            need = {3'd0, cnt} << nvcd_pkg::kind_shift(col_kind_d);
            if (cnt[31]) begin
              fin_emit = 1'b1; fin_status = nvcd_pkg::ST_NEG_COUNT;
            end else if (cnt > room) begin
              fin_emit = 1'b1; fin_status = nvcd_pkg::ST_VALUE_LIMIT;
            end else if (need > {3'd0, bytes_left_d}) begin
              fin_emit = 1'b1; fin_status = nvcd_pkg::ST_PAYLOAD_TRUNC;
            end else begin
              total_d     = total_d + cnt;
              inner_tgt_d = cnt;
              inner_cnt_d = '0;
              pos_d       = '0;
              shift_d     = '0;
              if (cnt == '0) outer_cnt_d = outer_cnt_d + 32'd1;
              phase_d = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          bytes_left_d = bytes_left_d - 32'd1;
          shift_d      = {shift_d[55:0], data_byte_i};
          pos_d        = pos_d + 4'd1;
          if (pos_d == nvcd_pkg::kind_width(col_kind_d)) begin
            val_emit    = 1'b1;
            val_raw     = shift_d;
            val_oi      = outer_cnt_d[30:0];
            val_ii      = inner_cnt_d[30:0];
            pos_d       = '0;
            shift_d     = '0;
            inner_cnt_d = inner_cnt_d + 32'd1;
            if (inner_cnt_d == inner_tgt_d) begin
              outer_cnt_d = outer_cnt_d + 32'd1;
              phase_d     = PH_LEN;
            end
          end
        end
        default: ;
      endcase

      // next-outer decision where a vector boundary has been reached
      if (!fin_emit && !first_byte_i || !fin_emit && phase_q == PH_IDLE) begin
        if (
          (phase_q == PH_VERSION && phase_d == PH_LEN) ||
          (phase_q == PH_CHECKSUM && phase_d == PH_LEN) ||
          (phase_q == PH_COUNT && phase_d == PH_LEN) ||
          (phase_q == PH_LEN && phase_d == PH_VALUE && inner_tgt_d == '0 &&
           pos_q == 4'd3) ||
          (phase_q == PH_VALUE && phase_d == PH_LEN)
        ) begin
          if (outer_cnt_d == outer_tgt_d) begin
            fin_emit   = 1'b1;
            fin_status = (bytes_left_d != '0) ? nvcd_pkg::ST_SIZE_MISMATCH : nvcd_pkg::ST_OK;
          end else if (bytes_left_d < 32'd4) begin
            fin_emit = 1'b1; fin_status = nvcd_pkg::ST_LEN_TRUNC;
          end else begin
            phase_d = PH_LEN;
            pos_d   = '0;
            shift_d = '0;
          end
        end
      end

      if (fin_emit) phase_d = PH_IDLE;
    end
  end

  // results towards the queue, value first
  always_comb begin
    nvcd_pkg::nvcd_entry_t v, f;
    v = '0;
    v.raw         = val_raw;
    v.kind        = col_kind_d;
    v.has_value   = 1'b1;
    v.outer_index = val_oi;
    v.inner_index = val_ii;
    f = '0;
    f.column_done = 1'b1;
    f.status      = fin_status;
    ent_a_o  = val_emit ? v : f;
    ent_b_o  = f;
    n_push_o = {1'b0, val_emit} + {1'b0, fin_emit};
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bytes_left_q <= '0;
      header_q     <= '0;
      outer_cnt_q  <= '0;
      outer_tgt_q  <= '0;
      inner_cnt_q  <= '0;
      inner_tgt_q  <= '0;
      shift_q      <= '0;
      pos_q        <= '0;
      total_q      <= '0;
      col_kind_q   <= '0;
      col_avail_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      header_q     <= header_d;
      outer_cnt_q  <= outer_cnt_d;
      outer_tgt_q  <= outer_tgt_d;
      inner_cnt_q  <= inner_cnt_d;
      inner_tgt_q  <= inner_tgt_d;
      shift_q      <= shift_d;
      pos_q        <= pos_d;
      total_q      <= total_d;
      col_kind_q   <= col_kind_d;
      col_avail_q  <= col_avail_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_kind_q <= nvcd_pkg::KIND_BOOL;
      cfg_max_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nvcd_pkg::CFG_VALUE_KIND: cfg_kind_q <= cfg_data_i[3:0];
        nvcd_pkg::CFG_MAX_TOTAL:  cfg_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[sv/nvcd_fifo.sv]
// ----------------------------------------------------------------------------
// nvcd_fifo
// Four-entry result queue taking up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module nvcd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nvcd_pkg::nvcd_entry_t ent_a_i,
  input  nvcd_pkg::nvcd_entry_t ent_b_i,
  input  logic [1:0]            n_push_i,
  input  logic                  pop_i,
  output logic                  space_o,
  output logic                  head_valid_o,
  output nvcd_pkg::nvcd_entry_t head_o
);

  nvcd_pkg::nvcd_entry_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign head_valid_o = (cnt_q != 3'd0);
  assign head_o       = mem_q[rd_q];
  assign space_o      = (cnt_q <= 3'd2);
  assign do_pop       = pop_i && head_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (n_push_i != 2'd0) mem_q[wr_q] <= ent_a_i;
    if (n_push_i == 2'd2) mem_q[wr_q + 2'd1] <= ent_b_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push_i;
      rd_q  <= rd_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, n_push_i} - {2'b0, do_pop};
    end
  end

endmodule

[sv/nvcd_convert.sv]
// ----------------------------------------------------------------------------
// nvcd_convert
// Four-stage conversion of raw primitives to binary64, ending in the output
// register.
// ----------------------------------------------------------------------------
module nvcd_convert (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  nvcd_pkg::nvcd_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           value_bits_o,
  output logic                  has_value_o,
  output logic [30:0]           outer_index_o,
  output logic [30:0]           inner_index_o,
  output logic                  column_done_o,
  output logic [3:0]            status_o
);

  typedef struct packed {
    logic        has_value;
    logic [30:0] outer_index;
    logic [30:0] inner_index;
    logic        column_done;
    logic [3:0]  status;
  } meta_t;

  typedef struct packed {
    logic        direct;
    logic [63:0] bits;
    logic        sign;
    logic [10:0] base;
  } num_t;

  logic        adv;
  logic        v1_q, v2_q, v3_q, vo_q;
  meta_t       m1_q, m2_q, m3_q, mo_q;
  num_t        n1_d, n1_q, n2_q, n3_q;
  logic [6:0]  lz_d, lz_q;
  logic [63:0] norm_d;
  logic [10:0] exp_d, exp_q;
  logic [63:0] res_d, vo_bits_q;

  assign adv   = !vo_q || out_ready_i;
  assign pop_o = adv;

  // stage 1: sign and magnitude
  always_comb begin
    logic [63:0] sx;
    logic [7:0]  fe;
    logic [22:0] fm;
    sx = '0;
    fe = head_i.raw[30:23];
    fm = head_i.raw[22:0];
    n1_d = '0;
    n1_d.base = 11'd1023;
    if (!head_i.has_value) begin
      n1_d.direct = 1'b1;
    end else begin
      unique case (head_i.kind)
        nvcd_pkg::KIND_BOOL: begin
          n1_d.direct = 1'b1;
          n1_d.bits   = (head_i.raw != '0) ? 64'h3ff0_0000_0000_0000 : '0;
        end
        nvcd_pkg::KIND_INT8, nvcd_pkg::KIND_INT16,
        nvcd_pkg::KIND_INT32, nvcd_pkg::KIND_INT64: begin
          if (head_i.kind == nvcd_pkg::KIND_INT8)
            sx = {{56{head_i.raw[7]}}, head_i.raw[7:0]};
          else if (head_i.kind == nvcd_pkg::KIND_INT16)
            sx = {{48{head_i.raw[15]}}, head_i.raw[15:0]};
          else if (head_i.kind == nvcd_pkg::KIND_INT32)
            sx = {{32{head_i.raw[31]}}, head_i.raw[31:0]};
          else
            sx = head_i.raw;
          n1_d.sign = sx[63];
          n1_d.bits = sx[63] ? (~sx + 64'd1) : sx;
        end
        nvcd_pkg::KIND_FLOAT32: begin
          if (fe == 8'hff) begin
            n1_d.direct = 1'b1;
            n1_d.bits   = {head_i.raw[31], 11'h7ff, (fm != '0), fm[21:0], 29'd0};
          end else if (fe == 8'h00) begin
            if (fm == '0) begin
              n1_d.direct = 1'b1;
              n1_d.bits   = {head_i.raw[31], 63'd0};
            end else begin
              n1_d.sign = head_i.raw[31];
              n1_d.bits = {41'd0, fm};
              n1_d.base = 11'd874 - 11'd63 + 11'd63;
            end
          end else begin
            n1_d.direct = 1'b1;
            n1_d.bits   = {head_i.raw[31], {3'd0, fe} + 11'd896, fm, 29'd0};
          end
        end
        nvcd_pkg::KIND_FLOAT64: begin
          n1_d.direct = 1'b1;
          n1_d.bits   = head_i.raw;
        end
        default: n1_d.bits = head_i.raw;
      endcase
    end
  end

  // stage 2: leading zero count
  always_comb begin
    lz_d = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (n1_q.bits[i]) lz_d = 7'(63 - i);
    end
  end

  // stage 3: normalise and exponent
  always_comb begin
    norm_d = n2_q.bits << lz_q[5:0];
    exp_d  = n2_q.base + 11'd63 - {4'd0, lz_q};
  end

  // stage 4: round to nearest even and pack
  always_comb begin
    logic up;
    up = n3_q.bits[10] && ((n3_q.bits[9:0] != '0) || n3_q.bits[11]);
    if (n3_q.direct) res_d = n3_q.bits;
    else if (n3_q.bits[63] == 1'b0) res_d = {n3_q.sign, 63'd0};
    else res_d = {n3_q.sign, exp_q, n3_q.bits[62:11]} + {63'd0, up};
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= head_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q      <= '{head_i.has_value, head_i.outer_index, head_i.inner_index,
                     head_i.column_done, head_i.status};
      n1_q      <= n1_d;
      m2_q      <= m1_q;
      n2_q      <= n1_q;
      lz_q      <= lz_d;
      m3_q      <= m2_q;
      n3_q      <= n2_q.direct ? n2_q : num_t'{1'b0, norm_d, n2_q.sign, n2_q.base};
      exp_q     <= exp_d;
      mo_q      <= m3_q;
      vo_bits_q <= res_d;
    end
  end

  assign out_valid_o   = vo_q;
  assign value_bits_o  = vo_bits_q;
  assign has_value_o   = mo_q.has_value;
  assign outer_index_o = mo_q.outer_index;
  assign inner_index_o = mo_q.inner_index;
  assign column_done_o = mo_q.column_done;
  assign status_o      = mo_q.status;

endmodule

[sv/nested_vector_column_decoder_top.sv]
// ----------------------------------------------------------------------------
// nested_vector_column_decoder_top
// Deframes a column of nested vectors into binary64 values with indices.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid_i/in_ready_o) carries one column byte per
//   transaction; first_byte_i starts a new column and latches
//   column_available_i and outer_vectors_i
// - output channel (out_valid_o/out_ready_i) carries value transactions and
//   one final transaction per column with column_done_o and status_o
// - a byte yields zero, one or two output transactions; they go through a
//   four-entry queue and a four-stage binary64 conversion pipeline
// - an accepted byte's results are written into the queue at the accepting
//   edge and then pass through the four registered conversion stages
// - throughput: one byte per cycle while the queue holds at most two
//   entries; one output transaction per cycle while out_ready_i is high
// - the value_kind and max_total_values registers are written on the
//   cfg_we_i port; the kind is latched at each column start
// - reset empties queue and pipeline and leaves the parser idle; bytes
//   arriving while idle without first_byte_i are dropped
// - when the receiver stalls, the pipeline holds, the queue fills and
//   in_ready_o falls
// ----------------------------------------------------------------------------
module nested_vector_column_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [31:0] column_available_i,
  input  logic [31:0] outer_vectors_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_bits_o,
  output logic        has_value_o,
  output logic [30:0] outer_index_o,
  output logic [30:0] inner_index_o,
  output logic        column_done_o,
  output logic [3:0]  status_o
);

  nvcd_pkg::nvcd_entry_t ent_a, ent_b, head;
  logic [1:0] n_push;
  logic       space, head_valid, pop;

  assign in_ready_o = space;

  // byte parser
  nvcd_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_valid_i && space),
    .data_byte_i        (data_byte_i),
    .first_byte_i       (first_byte_i),
    .column_available_i (column_available_i),
    .outer_vectors_i    (outer_vectors_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .ent_a_o            (ent_a),
    .ent_b_o            (ent_b),
    .n_push_o           (n_push)
  );

  // result queue
  nvcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_a_i      (ent_a),
    .ent_b_i      (ent_b),
    .n_push_i     (n_push),
    .pop_i        (pop),
    .space_o      (space),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // binary64 conversion and output register
  nvcd_convert u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_bits_o  (value_bits_o),
    .has_value_o   (has_value_o),
    .outer_index_o (outer_index_o),
    .inner_index_o (inner_index_o),
    .column_done_o (column_done_o),
    .status_o      (status_o)
  );

endmodule
